@@ hdl/p8tmr_pkg.sv @@
package p8tmr_pkg;

  // Operation carried by one input item
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_WRITE_CNT = 2'd1,
    OP_CLR_FLAGS = 2'd2,
    OP_WRITE_PIN = 2'd3
  } opcode_t;

  // Waveform generation modes
  localparam logic [1:0] WGM_NORMAL = 2'd0;
  localparam logic [1:0] WGM_PHASE  = 2'd1;
  localparam logic [1:0] WGM_CTC    = 2'd2;
  localparam logic [1:0] WGM_FAST   = 2'd3;

  // Compare output actions
  localparam logic [1:0] COM_OFF    = 2'd0;
  localparam logic [1:0] COM_TOGGLE = 2'd1;
  localparam logic [1:0] COM_CLEAR  = 2'd2;
  localparam logic [1:0] COM_SET    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_CLOCK_SELECT  = 2'd0;
  localparam logic [1:0] REG_WAVEFORM_MODE = 2'd1;
  localparam logic [1:0] REG_OUTPUT_MODE   = 2'd2;

  localparam logic [2:0] CS_STOPPED = 3'd0;
  localparam logic [7:0] CNT_TOP    = 8'hFF;
  localparam logic [7:0] CNT_BOTTOM = 8'h00;

  // Last prescaler count before the counter advances (divisor - 1)
  function automatic logic [9:0] presc_last(input logic [2:0] sel);
    logic [9:0] r;
    case (sel)
      3'd1:    r = 10'd0;
      3'd2:    r = 10'd7;
      3'd3:    r = 10'd31;
      3'd4:    r = 10'd63;
      3'd5:    r = 10'd127;
      3'd6:    r = 10'd255;
      3'd7:    r = 10'd1023;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // Pin action for normal and CTC modes
  function automatic logic pin_plain(input logic [1:0] om, input logic en, input logic pin);
    logic r;
    r = pin;
    if (en) begin
      case (om)
        COM_TOGGLE: r = ~pin;
        COM_CLEAR:  r = 1'b0;
        COM_SET:    r = 1'b1;
        default:    r = pin;
      endcase
    end
    return r;
  endfunction

  // Pin action for fast PWM; match low means the wrap at top
  function automatic logic pin_fast(input logic [1:0] om, input logic en, input logic match,
                                    input logic pin);
    logic r;
    r = pin;
    if (en) begin
      case (om)
        COM_TOGGLE: r = match ? ~pin : pin;
        COM_CLEAR:  r = ~match;
        COM_SET:    r = match;
        default:    r = pin;
      endcase
    end
    return r;
  endfunction

  // Pin action for phase correct PWM; toggle is reserved there
  function automatic logic pin_phase(input logic [1:0] om, input logic en, input logic up,
                                     input logic pin);
    logic r;
    r = pin;
    if (en) begin
      case (om)
        COM_CLEAR: r = ~up;
        COM_SET:   r = up;
        default:   r = pin;
      endcase
    end
    return r;
  endfunction

endpackage

@@ hdl/prescaled_8bit_timer_pwm.sv @@
// 8-bit timer/counter with prescaler, four waveform modes and one compare pin.
// Input channel (in_valid/in_ready) carries one item per io clock tick or
// register access: opcode, write_data, compare_value, pin_drive_enable.
// Output channel (out_valid/out_ready) returns one item per input item: the
// counter, both sticky flags, the pin level and the count direction after
// that item.
// The result of an accepted item is registered in the timer state and shows on
// the outputs in the next cycle. Throughput is one item per cycle while
// out_ready stays high; the timer state registers are the result registers,
// so the next item is taken in the same cycle that the current result is taken.
// When the receiver stalls, in_ready drops and the timer holds its state,
// since each item is one tick of time that has not yet happened.
// Configuration (cfg_write/cfg_index/cfg_data) is registered on cfg_write and
// should only change while no item is pending.
// Synchronous reset: stopped clock, counter and flags zero, pin high,
// output channel empty.
module prescaled_8bit_timer_pwm (
  input  logic       clk,
  input  logic       rst,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [7:0] write_data,
  input  logic [7:0] compare_value,
  input  logic       pin_drive_enable,
  // result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] count,
  output logic       overflow_flag,
  output logic       compare_flag,
  output logic       pin_level,
  output logic       down_counting,
  // configuration
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  logic [2:0] clock_select;
  logic [1:0] waveform_mode;
  logic [1:0] output_mode;

  logic [7:0] count_value, count_value_next;
  logic [9:0] prescale_count, prescale_count_next;
  logic [2:0] active_sel, active_sel_next;
  logic [7:0] compare_buffer, compare_buffer_next;
  logic       overflow_bit, overflow_bit_next;
  logic       compare_bit, compare_bit_next;
  logic       pin_bit, pin_bit_next;
  logic       counting_down, counting_down_next;
  logic       missed_compare, missed_compare_next;

  logic in_fire;

  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_select  <= p8tmr_pkg::CS_STOPPED;
      waveform_mode <= p8tmr_pkg::WGM_NORMAL;
      output_mode   <= p8tmr_pkg::COM_OFF;
    end else if (cfg_write) begin
      case (cfg_index)
        p8tmr_pkg::REG_CLOCK_SELECT:  clock_select  <= cfg_data;
        p8tmr_pkg::REG_WAVEFORM_MODE: waveform_mode <= cfg_data[1:0];
        p8tmr_pkg::REG_OUTPUT_MODE:   output_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Next timer state for one item
  always_comb begin
    logic [9:0] presc_base;
    logic [7:0] cmp;
    logic       en;
    cmp = compare_value;
    en  = pin_drive_enable;
    presc_base          = prescale_count;
    count_value_next    = count_value;
    prescale_count_next = prescale_count;
    active_sel_next     = active_sel;
    compare_buffer_next = compare_buffer;
    overflow_bit_next   = overflow_bit;
    compare_bit_next    = compare_bit;
    pin_bit_next        = pin_bit;
    counting_down_next  = counting_down;
    missed_compare_next = missed_compare;

    if (in_fire) begin
      case (p8tmr_pkg::opcode_t'(opcode))
        p8tmr_pkg::OP_TICK: begin
          if (clock_select == p8tmr_pkg::CS_STOPPED) begin
            active_sel_next     = p8tmr_pkg::CS_STOPPED;
            prescale_count_next = '0;
          end else begin
            // divisor change restarts the prescaler
            if (clock_select != active_sel) begin
              if (active_sel == p8tmr_pkg::CS_STOPPED && count_value > cmp)
                missed_compare_next = 1'b1;
              active_sel_next = clock_select;
              presc_base      = '0;
            end else begin
              missed_compare_next = 1'b0;
            end

            if (presc_base == p8tmr_pkg::presc_last(clock_select)) begin
              prescale_count_next = '0;
              // counter advance, per waveform mode
              case (waveform_mode)
                p8tmr_pkg::WGM_NORMAL: begin
                  if (count_value == p8tmr_pkg::CNT_TOP) begin
                    count_value_next  = '0;
                    overflow_bit_next = 1'b1;
                    pin_bit_next      = p8tmr_pkg::pin_plain(output_mode, en, pin_bit);
                  end else begin
                    count_value_next = count_value + 8'd1;
                  end
                end
                p8tmr_pkg::WGM_CTC: begin
                  if (count_value == cmp) begin
                    count_value_next = '0;
                    compare_bit_next = 1'b1;
                    pin_bit_next     = p8tmr_pkg::pin_plain(output_mode, en, pin_bit);
                  end else begin
                    count_value_next = count_value + 8'd1;
                  end
                end
                p8tmr_pkg::WGM_FAST: begin
                  if (count_value == p8tmr_pkg::CNT_TOP) begin
                    count_value_next    = '0;
                    compare_buffer_next = cmp;
                    pin_bit_next = p8tmr_pkg::pin_fast(output_mode, en, 1'b0, pin_bit);
                    overflow_bit_next   = 1'b1;
                  end else begin
                    if (count_value == compare_buffer) begin
                      compare_bit_next = 1'b1;
                      pin_bit_next = p8tmr_pkg::pin_fast(output_mode, en, 1'b1, pin_bit);
                    end
                    count_value_next = count_value + 8'd1;
                  end
                end
                default: begin
                  // phase correct: turn around at top and bottom
                  if (count_value == p8tmr_pkg::CNT_TOP) begin
                    if (compare_buffer == p8tmr_pkg::CNT_TOP) compare_bit_next = 1'b1;
                    if (missed_compare_next ||
                        (compare_buffer == p8tmr_pkg::CNT_TOP && cmp != p8tmr_pkg::CNT_TOP))
                      pin_bit_next = p8tmr_pkg::pin_phase(output_mode, en, 1'b1, pin_bit_next);
                    counting_down_next  = 1'b1;
                    compare_buffer_next = cmp;
                    if (cmp == p8tmr_pkg::CNT_TOP)
                      pin_bit_next = p8tmr_pkg::pin_phase(output_mode, en, 1'b0, pin_bit_next);
                    count_value_next = count_value - 8'd1;
                  end else if (count_value == p8tmr_pkg::CNT_BOTTOM) begin
                    counting_down_next = 1'b0;
                    overflow_bit_next  = 1'b1;
                    count_value_next   = 8'd1;
                  end else begin
                    if (count_value == compare_buffer) begin
                      compare_bit_next = 1'b1;
                      pin_bit_next = p8tmr_pkg::pin_phase(output_mode, en, ~counting_down,
                                                          pin_bit);
                    end
                    count_value_next = counting_down ? count_value - 8'd1
                                                     : count_value + 8'd1;
                  end
                end
              endcase
            end else begin
              prescale_count_next = presc_base + 10'd1;
            end
          end
        end
        p8tmr_pkg::OP_WRITE_CNT: count_value_next = write_data;
        p8tmr_pkg::OP_CLR_FLAGS: begin
          if (write_data[0]) overflow_bit_next = 1'b0;
          if (write_data[1]) compare_bit_next  = 1'b0;
        end
        p8tmr_pkg::OP_WRITE_PIN: pin_bit_next = write_data[0];
        default: ;
      endcase
    end
  end

  // Timer state, which is also the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_value    <= '0;
      prescale_count <= '0;
      active_sel     <= p8tmr_pkg::CS_STOPPED;
      compare_buffer <= '0;
      overflow_bit   <= 1'b0;
      compare_bit    <= 1'b0;
      pin_bit        <= 1'b1;
      counting_down  <= 1'b0;
      missed_compare <= 1'b0;
    end else begin
      count_value    <= count_value_next;
      prescale_count <= prescale_count_next;
      active_sel     <= active_sel_next;
      compare_buffer <= compare_buffer_next;
      overflow_bit   <= overflow_bit_next;
      compare_bit    <= compare_bit_next;
      pin_bit        <= pin_bit_next;
      counting_down  <= counting_down_next;
      missed_compare <= missed_compare_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign count         = count_value;
  assign overflow_flag = overflow_bit;
  assign compare_flag  = compare_bit;
  assign pin_level     = pin_bit;
  assign down_counting = counting_down;

endmodule
